@@ rtl/core/sclt_pkg.sv @@
// types and constants shared by the channel lock table modules
package sclt_pkg;

   localparam int ID_W     = 4;
   localparam int SAMPLE_W = 16;
   localparam int BUS_OUT_W = 4;

   typedef enum logic [1:0] {
      OP_PORT_UPDATE,
      OP_BUS_UP,
      OP_BUS_DOWN,
      OP_REGISTER
   } opcode_type;

   localparam logic [1:0] STATUS_DONE   = 2'd0;
   localparam logic [1:0] STATUS_LIMIT  = 2'd1;
   localparam logic [1:0] STATUS_MISUSE = 2'd2;

   localparam logic [1:0] LOCK_FREE  = 2'd0;
   localparam logic [1:0] LOCK_MINE  = 2'd1;
   localparam logic [1:0] LOCK_OTHER = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_PU_RD,
      S_PU_WR,
      S_ID_RD,
      S_REL_RD,
      S_REL_WR,
      S_ENT_RD,
      S_ENT_WR
   } state_type;

   typedef struct packed {
      logic rd;
      logic upd;
      logic rel;
      logic clr;
   } pt_ctl_type;

   typedef struct packed {
      logic [1:0]                 lock;
      logic signed [SAMPLE_W-1:0] value;
   } pt_res_type;

endpackage

@@ rtl/core/sclt_port_table.sv @@
// port owner and sample memory with the owner compare and update unit
module sclt_port_table #(
   parameter int ADDR_W = 8
) (
   input  logic                                 clock,
   input  sclt_pkg::pt_ctl_type                 ctl,
   input  logic [ADDR_W-1:0]                    addr,
   input  logic [sclt_pkg::ID_W-1:0]            me,
   input  logic                                 drive,
   input  logic signed [sclt_pkg::SAMPLE_W-1:0] sample,
   output sclt_pkg::pt_res_type                 res
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [sclt_pkg::ID_W-1:0]            owner_mem [DEPTH];
   logic signed [sclt_pkg::SAMPLE_W-1:0] sample_mem [DEPTH];

   logic [sclt_pkg::ID_W-1:0]            owner_rd_ff;
   logic signed [sclt_pkg::SAMPLE_W-1:0] sample_rd_ff;
   logic [ADDR_W-1:0]                    addr_ff;

   logic                                 we;
   logic [ADDR_W-1:0]                    waddr;
   logic [sclt_pkg::ID_W-1:0]            owner_new;
   logic signed [sclt_pkg::SAMPLE_W-1:0] sample_new;
   logic [sclt_pkg::ID_W-1:0]            upd_owner;
   logic signed [sclt_pkg::SAMPLE_W-1:0] upd_sample;

   // read-modify-write of one entry
   always_comb begin
      upd_owner  = owner_rd_ff;
      upd_sample = sample_rd_ff;
      if (drive) begin
         if (owner_rd_ff == '0) begin
            upd_owner = me;
         end
         if (upd_owner == me) begin
            upd_sample = sample;
         end
      end else if (owner_rd_ff == me) begin
         upd_owner  = '0;
         upd_sample = '0;
      end
   end

   always_comb begin
      if (upd_owner == '0) begin
         res.lock = sclt_pkg::LOCK_FREE;
      end else if (upd_owner == me) begin
         res.lock = sclt_pkg::LOCK_MINE;
      end else begin
         res.lock = sclt_pkg::LOCK_OTHER;
      end
      res.value = upd_sample;
   end

   always_comb begin
      we         = 1'b0;
      waddr      = addr_ff;
      owner_new  = '0;
      sample_new = '0;
      if (ctl.clr) begin
         we    = 1'b1;
         waddr = addr;
      end else if (ctl.upd) begin
         we         = 1'b1;
         owner_new  = upd_owner;
         sample_new = upd_sample;
      end else if (ctl.rel) begin
         we         = (owner_rd_ff == me);
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         owner_mem[waddr]  <= owner_new;
         sample_mem[waddr] <= sample_new;
      end
      if (ctl.rd) begin
         owner_rd_ff  <= owner_mem[addr];
         sample_rd_ff <= sample_mem[addr];
         addr_ff      <= addr;
      end
   end

endmodule

@@ rtl/core/shared_channel_lock_table.sv @@
// top level of the shared channel lock table: sequencer, id tables and client state
//
// Clients share NUM_BUSES buses of NUM_PORTS ports. A request is taken at a rising
// edge with start high and busy low; its fields sit on the req_ ports. Opcodes:
// port update, bus up, bus down and client registration. Every request gives one
// response, shown on the rsp_ ports for one cycle with rsp_valid high. The
// receiver cannot stall; responses are never held back.
// Steps from the accepting edge to the registered response:
//   rejected request (misuse or bus limit): registered at the accepting edge
//   port update: id and port reads, then the update write
//   registration: id and counter reads, then id and counter writes
//   bus up or down: id read, a release pass, then the registration steps;
//   the release reads and writes the single port table port per old-bus port.
// busy falls with the response, so the next request may enter in the cycle
// the response is shown. The port table port sets the rate.
// After reset busy stays high for a clearing pass over 2**CLR_W addresses
// (256 with the defaults), which zeroes the port, id and counter tables.
module shared_channel_lock_table #(
   parameter int NUM_BUSES   = 16,
   parameter int NUM_PORTS   = 10,
   parameter int MAX_CLIENTS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_opcode,
   input  logic [2:0]                           req_client,
   input  logic [3:0]                           req_port,
   input  logic                                 req_drive_active,
   input  logic signed [sclt_pkg::SAMPLE_W-1:0] req_sample_value,
   output logic                                 rsp_valid,
   output logic signed [sclt_pkg::SAMPLE_W-1:0] rsp_port_value,
   output logic [1:0]                           rsp_lock_status,
   output logic [sclt_pkg::BUS_OUT_W-1:0]       rsp_current_bus,
   output logic [1:0]                           rsp_status
);

   localparam int BUS_W  = (NUM_BUSES > 1) ? $clog2(NUM_BUSES) : 1;
   localparam int PORT_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
   localparam int CL_W   = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
   localparam int PT_AW  = BUS_W + PORT_W;
   localparam int ID_AW  = CL_W + BUS_W;
   localparam int CLR_W  = (PT_AW > ID_AW) ? PT_AW : ID_AW;
   localparam int ID_DEPTH  = 1 << ID_AW;
   localparam int CTR_DEPTH = 1 << BUS_W;

   localparam logic [BUS_W-1:0]  BUS_LAST  = BUS_W'(NUM_BUSES - 1);
   localparam logic [PORT_W-1:0] PORT_LAST = PORT_W'(NUM_PORTS - 1);

   sclt_pkg::state_type state_ff, state_in;

   logic [CLR_W-1:0]                     clr_ff, clr_in;
   logic [CL_W-1:0]                      cl_ff, cl_in;
   logic [PORT_W-1:0]                    port_ff, port_in;
   logic                                 drive_ff, drive_in;
   logic signed [sclt_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic [BUS_W-1:0]                     bus_ff, bus_in;
   logic [BUS_W-1:0]                     tgt_ff, tgt_in;
   logic [PORT_W-1:0]                    rel_port_ff, rel_port_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [sclt_pkg::SAMPLE_W-1:0] rsp_port_value_ff, rsp_port_value_in;
   logic [1:0]                           rsp_lock_status_ff, rsp_lock_status_in;
   logic [sclt_pkg::BUS_OUT_W-1:0]       rsp_current_bus_ff, rsp_current_bus_in;
   logic [1:0]                           rsp_status_ff, rsp_status_in;

   logic [BUS_W-1:0] client_bus_ff [MAX_CLIENTS];
   logic             client_reg_ff [MAX_CLIENTS];
   logic             client_we;

   logic [sclt_pkg::ID_W-1:0] id_mem [ID_DEPTH];
   logic [sclt_pkg::ID_W-1:0] id_rd_ff;
   logic                      id_re, id_we;
   logic [ID_AW-1:0]          id_raddr, id_waddr;
   logic [sclt_pkg::ID_W-1:0] id_wdata;

   logic [sclt_pkg::ID_W-1:0] ctr_mem [CTR_DEPTH];
   logic [sclt_pkg::ID_W-1:0] ctr_rd_ff;
   logic                      ctr_re, ctr_we;
   logic [BUS_W-1:0]          ctr_raddr, ctr_waddr;
   logic [sclt_pkg::ID_W-1:0] ctr_wdata;
   logic [sclt_pkg::ID_W-1:0] fresh_id;

   sclt_pkg::pt_ctl_type pt_ctl;
   logic [PT_AW-1:0]     pt_addr;
   sclt_pkg::pt_res_type pt_res;

   logic                 accept;
   sclt_pkg::opcode_type req_op;
   logic [CL_W-1:0]      req_cl;
   logic                 cl_oor;
   logic                 port_oor;
   logic                 cur_reg;
   logic [BUS_W-1:0]     cur_bus;
   logic                 early_hit;
   logic [1:0]           early_status;

   assign busy     = (state_ff != sclt_pkg::S_IDLE);
   assign accept   = start && !busy;
   assign req_op   = sclt_pkg::opcode_type'(req_opcode);
   assign req_cl   = CL_W'(req_client);
   assign cl_oor   = 6'(req_client) >= 6'(MAX_CLIENTS);
   assign port_oor = 7'(req_port) >= 7'(NUM_PORTS);
   assign cur_reg  = client_reg_ff[req_cl];
   assign cur_bus  = client_bus_ff[req_cl];
   assign fresh_id = (ctr_rd_ff == '1) ? sclt_pkg::ID_W'(1)
                                       : ctr_rd_ff + sclt_pkg::ID_W'(1);

   // checks that end a request at once
   always_comb begin
      early_hit    = 1'b1;
      early_status = sclt_pkg::STATUS_MISUSE;
      if (cl_oor) begin
         early_hit = 1'b1;
      end else if (req_op == sclt_pkg::OP_REGISTER) begin
         early_hit = cur_reg;
      end else if (!cur_reg) begin
         early_hit = 1'b1;
      end else begin
         case (req_op)
            sclt_pkg::OP_PORT_UPDATE: early_hit = port_oor;
            sclt_pkg::OP_BUS_UP: begin
               early_hit    = (cur_bus == BUS_LAST);
               early_status = sclt_pkg::STATUS_LIMIT;
            end
            default: begin
               early_hit    = (cur_bus == '0);
               early_status = sclt_pkg::STATUS_LIMIT;
            end
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sclt_pkg::S_CLEAR: begin
            if (clr_ff == '1) state_in = sclt_pkg::S_IDLE;
         end
         sclt_pkg::S_IDLE: begin
            if (accept && !early_hit) begin
               unique case (req_op)
                  sclt_pkg::OP_PORT_UPDATE: state_in = sclt_pkg::S_PU_RD;
                  sclt_pkg::OP_REGISTER:    state_in = sclt_pkg::S_ENT_RD;
                  default:                  state_in = sclt_pkg::S_ID_RD;
               endcase
            end
         end
         sclt_pkg::S_PU_RD:  state_in = sclt_pkg::S_PU_WR;
         sclt_pkg::S_PU_WR:  state_in = sclt_pkg::S_IDLE;
         sclt_pkg::S_ID_RD:  state_in = sclt_pkg::S_REL_RD;
         sclt_pkg::S_REL_RD: state_in = sclt_pkg::S_REL_WR;
         sclt_pkg::S_REL_WR: begin
            state_in = (rel_port_ff == PORT_LAST) ? sclt_pkg::S_ENT_RD : sclt_pkg::S_REL_RD;
         end
         sclt_pkg::S_ENT_RD: state_in = sclt_pkg::S_ENT_WR;
         sclt_pkg::S_ENT_WR: state_in = sclt_pkg::S_IDLE;
         default:            state_in = sclt_pkg::S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      clr_in             = clr_ff;
      cl_in              = cl_ff;
      port_in            = port_ff;
      drive_in           = drive_ff;
      sample_in          = sample_ff;
      bus_in             = bus_ff;
      tgt_in             = tgt_ff;
      rel_port_in        = rel_port_ff;
      rsp_valid_in       = 1'b0;
      rsp_port_value_in  = '0;
      rsp_lock_status_in = sclt_pkg::LOCK_FREE;
      rsp_current_bus_in = rsp_current_bus_ff;
      rsp_status_in      = sclt_pkg::STATUS_DONE;
      client_we          = 1'b0;
      id_re              = 1'b0;
      id_raddr           = {cl_ff, bus_ff};
      id_we              = 1'b0;
      id_waddr           = {cl_ff, tgt_ff};
      id_wdata           = fresh_id;
      ctr_re             = 1'b0;
      ctr_raddr          = tgt_ff;
      ctr_we             = 1'b0;
      ctr_waddr          = tgt_ff;
      ctr_wdata          = fresh_id;
      pt_ctl             = '0;
      pt_addr            = {bus_ff, port_ff};
      unique case (state_ff)
         sclt_pkg::S_CLEAR: begin
            clr_in    = clr_ff + CLR_W'(1);
            id_we     = 1'b1;
            id_waddr  = ID_AW'(clr_ff);
            id_wdata  = '0;
            ctr_we    = 1'b1;
            ctr_waddr = BUS_W'(clr_ff);
            ctr_wdata = '0;
            pt_ctl.clr = 1'b1;
            pt_addr    = PT_AW'(clr_ff);
         end
         sclt_pkg::S_IDLE: begin
            if (accept) begin
               cl_in       = req_cl;
               port_in     = PORT_W'(req_port);
               drive_in    = req_drive_active;
               sample_in   = req_sample_value;
               bus_in      = cur_bus;
               rel_port_in = '0;
               case (req_op)
                  sclt_pkg::OP_BUS_UP:   tgt_in = cur_bus + BUS_W'(1);
                  sclt_pkg::OP_BUS_DOWN: tgt_in = cur_bus - BUS_W'(1);
                  sclt_pkg::OP_REGISTER: tgt_in = '0;
                  default:               tgt_in = cur_bus;
               endcase
               if (early_hit) begin
                  rsp_valid_in       = 1'b1;
                  rsp_status_in      = early_status;
                  rsp_current_bus_in = cl_oor ? '0 : sclt_pkg::BUS_OUT_W'(cur_bus);
               end
            end
         end
         sclt_pkg::S_PU_RD: begin
            id_re     = 1'b1;
            pt_ctl.rd = 1'b1;
         end
         sclt_pkg::S_PU_WR: begin
            pt_ctl.upd         = 1'b1;
            rsp_valid_in       = 1'b1;
            rsp_port_value_in  = pt_res.value;
            rsp_lock_status_in = pt_res.lock;
            rsp_current_bus_in = sclt_pkg::BUS_OUT_W'(bus_ff);
         end
         sclt_pkg::S_ID_RD: begin
            id_re = 1'b1;
         end
         sclt_pkg::S_REL_RD: begin
            pt_ctl.rd = 1'b1;
            pt_addr   = {bus_ff, rel_port_ff};
         end
         sclt_pkg::S_REL_WR: begin
            pt_ctl.rel = 1'b1;
            if (rel_port_ff != PORT_LAST) rel_port_in = rel_port_ff + PORT_W'(1);
         end
         sclt_pkg::S_ENT_RD: begin
            id_re    = 1'b1;
            id_raddr = {cl_ff, tgt_ff};
            ctr_re   = 1'b1;
         end
         sclt_pkg::S_ENT_WR: begin
            id_we              = (id_rd_ff == '0);
            ctr_we             = (id_rd_ff == '0);
            client_we          = 1'b1;
            rsp_valid_in       = 1'b1;
            rsp_current_bus_in = sclt_pkg::BUS_OUT_W'(tgt_ff);
         end
         default: begin
            clr_in = clr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sclt_pkg::S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_CLIENTS; i++) begin
            client_bus_ff[i] <= '0;
            client_reg_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (client_we) begin
            client_bus_ff[cl_ff] <= tgt_ff;
            client_reg_ff[cl_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cl_ff              <= cl_in;
      port_ff            <= port_in;
      drive_ff           <= drive_in;
      sample_ff          <= sample_in;
      bus_ff             <= bus_in;
      tgt_ff             <= tgt_in;
      rel_port_ff        <= rel_port_in;
      rsp_port_value_ff  <= rsp_port_value_in;
      rsp_lock_status_ff <= rsp_lock_status_in;
      rsp_current_bus_ff <= rsp_current_bus_in;
      rsp_status_ff      <= rsp_status_in;
   end

   // owner id per client and bus
   always_ff @(posedge clock) begin
      if (id_we) id_mem[id_waddr] <= id_wdata;
      if (id_re) id_rd_ff <= id_mem[id_raddr];
   end

   // last id handed out per bus
   always_ff @(posedge clock) begin
      if (ctr_we) ctr_mem[ctr_waddr] <= ctr_wdata;
      if (ctr_re) ctr_rd_ff <= ctr_mem[ctr_raddr];
   end

   sclt_port_table #(
      .ADDR_W (PT_AW)
   ) u_port_table (
      .clock  (clock),
      .ctl    (pt_ctl),
      .addr   (pt_addr),
      .me     (id_rd_ff),
      .drive  (drive_ff),
      .sample (sample_ff),
      .res    (pt_res)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_port_value  = rsp_port_value_ff;
   assign rsp_lock_status = rsp_lock_status_ff;
   assign rsp_current_bus = rsp_current_bus_ff;
   assign rsp_status      = rsp_status_ff;

   a_client_range: assert property (@(posedge clock) disable iff (reset)
      (accept && cl_oor) |=> (rsp_valid && rsp_status == sclt_pkg::STATUS_MISUSE
                              && rsp_current_bus == '0))
      else $error("out of range client not rejected");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != sclt_pkg::STATUS_DONE) |->
         (rsp_lock_status == sclt_pkg::LOCK_FREE && rsp_port_value == '0))
      else $error("rejected request carries port data");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sclt_pkg::S_CLEAR) |-> (!rsp_valid_ff && busy))
      else $error("activity during clearing pass");

   a_release_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sclt_pkg::S_REL_WR) |-> (rel_port_ff <= PORT_LAST))
      else $error("release pass past last port");

   a_enter_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sclt_pkg::S_ENT_WR) |=>
         (rsp_valid && !busy && rsp_current_bus == sclt_pkg::BUS_OUT_W'($past(tgt_ff))))
      else $error("bus entry response mismatch");

endmodule
